// ----- hw/rtl/planar_frame_rotation_defines.svh -----
// ---------------------------------------------------------------------------
// planar_frame_rotation_defines
// Assertion macros used by the checker file of the frame rotation block.
// ---------------------------------------------------------------------------
`ifndef PLANAR_FRAME_ROTATION_DEFINES_SVH
`define PLANAR_FRAME_ROTATION_DEFINES_SVH

// same-cycle implication
`define PFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("planar_frame_rotation: same-cycle check failed");

// next-cycle implication
`define PFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("planar_frame_rotation: next-cycle check failed");

`endif

// ----- hw/rtl/pfr_pkg.sv -----
// ---------------------------------------------------------------------------
// pfr_pkg
// Word types, CORDIC constants and the arctangent table of the frame rotator.
// ---------------------------------------------------------------------------
package pfr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int STAGE_CNT     = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int GUARD         = 12;

  localparam logic [31:0]        GAIN_K    = 32'd2608131496;
  localparam logic signed [64:0] ROUND_ADD = 65'sh800_0000_0000;
  localparam logic [31:0]        ANG_PI    = 32'h8000_0000;
  localparam logic [31:0]        HD_ROUND  = 32'h0000_8000;

  typedef struct packed {
    logic               to_local;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] comp_x;
    logic signed [15:0] comp_y;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] heading;
  } out_word_t;

  typedef struct packed {
    logic               loc;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] ang;
  } rot_t;

  typedef struct packed {
    logic               loc;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
  } gain_t;

  typedef struct packed {
    logic               loc;
    logic               zero;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] ang;
  } vec_t;

  function automatic logic [31:0] atan_ent(input int unsigned i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/pfr_rotator.sv -----
// ---------------------------------------------------------------------------
// pfr_rotator
// Quadrant fold and pipelined CORDIC rotation, one micro-rotation per stage.
// ---------------------------------------------------------------------------
module pfr_rotator
  import pfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_vld,
  input  in_word_t in_word,
  output logic     out_vld,
  output rot_t     out_rot
);

  rot_t        st_r   [STAGE_CNT+1];
  rot_t        st_nxt [STAGE_CNT+1];
  logic        vld_r  [STAGE_CNT+1];
  logic [15:0] yaw_eff;
  logic [31:0] ang0;
  logic        flip;
  logic signed [31:0] x0;
  logic signed [31:0] y0;

  always_comb begin
    yaw_eff = in_word.to_local ? 16'(16'h0 - in_word.yaw_angle) : in_word.yaw_angle;
    ang0    = {yaw_eff, 16'h0};
    flip    = ang0[31] ^ ang0[30];
    x0      = {{4{in_word.comp_x[15]}}, in_word.comp_x, 12'h0};
    y0      = {{4{in_word.comp_y[15]}}, in_word.comp_y, 12'h0};
    st_nxt[0].loc = in_word.to_local;
    st_nxt[0].x   = flip ? -x0 : x0;
    st_nxt[0].y   = flip ? -y0 : y0;
    st_nxt[0].ang = flip ? ang0 + ANG_PI : ang0;
  end

  for (genvar i = 0; i < STAGE_CNT; i++) begin : g_stage
    always_comb begin
      st_nxt[i+1].loc = st_r[i].loc;
      if (!st_r[i].ang[31]) begin
        st_nxt[i+1].x   = st_r[i].x - (st_r[i].y >>> i);
        st_nxt[i+1].y   = st_r[i].y + (st_r[i].x >>> i);
        st_nxt[i+1].ang = st_r[i].ang - atan_ent(i);
      end else begin
        st_nxt[i+1].x   = st_r[i].x + (st_r[i].y >>> i);
        st_nxt[i+1].y   = st_r[i].y - (st_r[i].x >>> i);
        st_nxt[i+1].ang = st_r[i].ang + atan_ent(i);
      end
    end
  end

  for (genvar k = 0; k <= STAGE_CNT; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= (k == 0) ? in_vld : vld_r[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_vld = vld_r[STAGE_CNT];
  assign out_rot = st_r[STAGE_CNT];

endmodule

// ----- hw/rtl/pfr_gain.sv -----
// ---------------------------------------------------------------------------
// pfr_gain
// CORDIC gain correction: multiply by 1/K, round half up, saturate to Q3.12.
// ---------------------------------------------------------------------------
module pfr_gain
  import pfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  rot_t  in_rot,
  output logic  out_vld,
  output gain_t out_gain
);

  logic signed [64:0] prod_x_r, prod_x_nxt;
  logic signed [64:0] prod_y_r, prod_y_nxt;
  logic               loc_r;
  logic               mul_vld_r;
  logic               sat_vld_r;
  gain_t              gain_r, gain_nxt;
  logic signed [64:0] sum_x, sum_y;

  function automatic logic signed [15:0] sat16(input logic signed [64:0] v);
    logic signed [15:0] r;
    if (v > 65'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -65'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign prod_x_nxt = in_rot.x * $signed({1'b0, GAIN_K});
  assign prod_y_nxt = in_rot.y * $signed({1'b0, GAIN_K});

  always_comb begin
    sum_x          = prod_x_r + ROUND_ADD;
    sum_y          = prod_y_r + ROUND_ADD;
    gain_nxt.loc   = loc_r;
    gain_nxt.rot_x = sat16(sum_x >>> (32 + GUARD));
    gain_nxt.rot_y = sat16(sum_y >>> (32 + GUARD));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      sat_vld_r <= 1'b0;
    end else if (en) begin
      mul_vld_r <= in_vld;
      sat_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      loc_r    <= in_rot.loc;
      gain_r   <= gain_nxt;
    end
  end

  assign out_vld  = sat_vld_r;
  assign out_gain = gain_r;

endmodule

// ----- hw/rtl/pfr_vectorer.sv -----
// ---------------------------------------------------------------------------
// pfr_vectorer
// Pipelined vectoring CORDIC for the heading, and the output word register.
// ---------------------------------------------------------------------------
module pfr_vectorer
  import pfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_vld,
  input  gain_t     in_gain,
  output logic      out_vld,
  output out_word_t out_word
);

  vec_t       st_r   [STAGE_CNT+1];
  vec_t       st_nxt [STAGE_CNT+1];
  logic       vld_r  [STAGE_CNT+1];
  logic       fin_vld_r;
  out_word_t  fin_r, fin_nxt;
  logic [31:0]        hd_ang;
  logic signed [31:0] x0;
  logic signed [31:0] y0;

  always_comb begin
    x0 = {{4{in_gain.rot_x[15]}}, in_gain.rot_x, 12'h0};
    y0 = {{4{in_gain.rot_y[15]}}, in_gain.rot_y, 12'h0};
    st_nxt[0].loc   = in_gain.loc;
    st_nxt[0].zero  = (in_gain.rot_x == 16'sh0) && (in_gain.rot_y == 16'sh0);
    st_nxt[0].rot_x = in_gain.rot_x;
    st_nxt[0].rot_y = in_gain.rot_y;
    st_nxt[0].x     = x0[31] ? -x0 : x0;
    st_nxt[0].y     = x0[31] ? -y0 : y0;
    st_nxt[0].ang   = x0[31] ? ANG_PI : 32'h0;
  end

  for (genvar i = 0; i < STAGE_CNT; i++) begin : g_stage
    always_comb begin
      st_nxt[i+1] = st_r[i];
      if (st_r[i].y[31]) begin
        st_nxt[i+1].x   = st_r[i].x - (st_r[i].y >>> i);
        st_nxt[i+1].y   = st_r[i].y + (st_r[i].x >>> i);
        st_nxt[i+1].ang = st_r[i].ang - atan_ent(i);
      end else begin
        st_nxt[i+1].x   = st_r[i].x + (st_r[i].y >>> i);
        st_nxt[i+1].y   = st_r[i].y - (st_r[i].x >>> i);
        st_nxt[i+1].ang = st_r[i].ang + atan_ent(i);
      end
    end
  end

  for (genvar k = 0; k <= STAGE_CNT; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= (k == 0) ? in_vld : vld_r[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_comb begin
    hd_ang        = st_r[STAGE_CNT].ang + HD_ROUND;
    fin_nxt.rot_x = st_r[STAGE_CNT].rot_x;
    fin_nxt.rot_y = st_r[STAGE_CNT].rot_y;
    fin_nxt.heading = (st_r[STAGE_CNT].loc && !st_r[STAGE_CNT].zero) ?
                      hd_ang[31:16] : 16'sh0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= vld_r[STAGE_CNT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  assign out_vld  = fin_vld_r;
  assign out_word = fin_r;

endmodule

// ----- hw/rtl/planar_frame_rotation.sv -----
// ---------------------------------------------------------------------------
// planar_frame_rotation
// Rotates a Q3.12 vector by +yaw or -yaw through a pipelined CORDIC and
// gives the heading of the result in global-to-local mode.
// ---------------------------------------------------------------------------
//  channel   ports                         word
//  in        in_valid  in_stall  in_data   to_local, yaw_angle, comp_x, comp_y
//  out       out_valid out_stall out_data  rot_x, rot_y, heading
//
//  One word per cycle while the pipe is not held; the stages in order:
//  rotation CORDIC, two gain stages, vectoring CORDIC, output register.
//  All stages advance together; out_stall on a valid output word holds the
//  whole pipe and raises in_stall.
//  Reset clears the valid bits only.
// ---------------------------------------------------------------------------
module planar_frame_rotation
  import pfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic  en;
  logic  rot_vld;
  rot_t  rot_word;
  logic  gain_vld;
  gain_t gain_word;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  pfr_rotator u_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_word (in_data),
    .out_vld (rot_vld),
    .out_rot (rot_word)
  );

  pfr_gain u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (rot_vld),
    .in_rot   (rot_word),
    .out_vld  (gain_vld),
    .out_gain (gain_word)
  );

  pfr_vectorer u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (gain_vld),
    .in_gain  (gain_word),
    .out_vld  (out_valid),
    .out_word (out_data)
  );

endmodule

// ----- hw/rtl/pfr_checker.sv -----
// ---------------------------------------------------------------------------
// pfr_checker
// Port-level checks of the frame rotation block, bound to the top level.
// ---------------------------------------------------------------------------
`include "planar_frame_rotation_defines.svh"

module pfr_checker
  import pfr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  logic in_seen;
  logic out_zero;

  assign in_seen  = in_valid || (in_data.to_local == 1'b0) || (in_data.to_local == 1'b1);
  assign out_zero = out_valid && (out_data.rot_x == 16'sh0) && (out_data.rot_y == 16'sh0);

  `PFR_ASSERT_NOW(a_hold_stalls_input, clk, rst_n, out_valid && out_stall && in_seen, in_stall)
  `PFR_ASSERT_NOW(a_empty_out_takes_input, clk, rst_n, !out_valid, !in_stall)
  `PFR_ASSERT_NOW(a_zero_vector_heading, clk, rst_n, out_zero, out_data.heading == 16'sh0)
  `PFR_ASSERT_NEXT(a_stalled_word_holds, clk, rst_n, out_valid && out_stall, $stable(out_data))

endmodule

bind planar_frame_rotation pfr_checker u_pfr_checker (.*);

// ----- tb/planar_frame_rotation_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// planar_frame_rotation_tb
// Sends yaw and vector words to the frame rotator with random gaps and output
// stalls. A bit-exact fixed-point CORDIC predictor works out the rotated
// vector and heading of each accepted word, and every result word is checked
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module planar_frame_rotation_tb;
  import pfr_pkg::*;

  localparam int    RANDOM_WORDS = 1450;
  localparam int    CYCLE_LIMIT  = 400000;
  localparam int    MAX_REPORTS  = 10;
  localparam int    DRAIN_CYCLES = 60;
  localparam longint GAIN_Q32    = 64'sd2608131496;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  bit [31:0] atan_lut [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  in_word_t  vectors_to_send [$];
  out_word_t rotations_due [$];
  int        vectors_queued = 0;
  int        results_seen   = 0;
  int        mismatches     = 0;
  int        cycles         = 0;
  int        send_gap       = 0;
  int        stall_left     = 0;
  bit        send_burst     = 1'b0;
  bit        recv_burst     = 1'b0;

  planar_frame_rotation u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  function automatic longint scale_saturate(longint v);
    longint r;
    r = (v * GAIN_Q32 + (longint'(1) <<< 43)) >>> 44;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic logic [15:0] vector_heading(longint x0, longint y0);
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    logic [31:0] ang;
    logic [31:0] rounded;
    int          i;
    if (x0 == 0 && y0 == 0) return 16'h0;
    x   = x0 <<< GUARD;
    y   = y0 <<< GUARD;
    ang = 32'h0;
    if (x < 0) begin
      x   = -x;
      y   = -y;
      ang = 32'h8000_0000;
    end
    for (i = 0; i < STAGE_CNT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x   = x - dx;
        y   = y + dy;
        ang = ang - atan_lut[i];
      end else begin
        x   = x + dx;
        y   = y - dy;
        ang = ang + atan_lut[i];
      end
    end
    rounded = ang + 32'h0000_8000;
    return rounded[31:16];
  endfunction

  function automatic out_word_t rotate_frame(in_word_t w);
    logic [15:0] yaw16;
    logic [31:0] ang;
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    out_word_t   r;
    int          i;
    yaw16 = w.yaw_angle;
    if (w.to_local) yaw16 = 16'h0 - w.yaw_angle;
    ang = {yaw16, 16'h0};
    x   = longint'(w.comp_x) <<< GUARD;
    y   = longint'(w.comp_y) <<< GUARD;
    if (ang[31] ^ ang[30]) begin
      x   = -x;
      y   = -y;
      ang = ang + 32'h8000_0000;
    end
    for (i = 0; i < STAGE_CNT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (!ang[31]) begin
        x   = x - dx;
        y   = y + dy;
        ang = ang - atan_lut[i];
      end else begin
        x   = x + dx;
        y   = y - dy;
        ang = ang + atan_lut[i];
      end
    end
    x         = scale_saturate(x);
    y         = scale_saturate(y);
    r.rot_x   = 16'(x);
    r.rot_y   = 16'(y);
    r.heading = w.to_local ? vector_heading(x, y) : 16'h0;
    return r;
  endfunction

  function automatic void queue_vector(bit loc, int yaw, int x, int y);
    in_word_t w;
    w.to_local  = loc;
    w.yaw_angle = 16'(yaw);
    w.comp_x    = 16'(x);
    w.comp_y    = 16'(y);
    vectors_to_send.push_back(w);
    vectors_queued++;
  endfunction

  function automatic int edge_value();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      6: return 4096;
      default: return 32767;
    endcase
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_random_vector();
    int yaw;
    int x;
    int y;
    yaw = $urandom_range(0, 65535);
    x   = $urandom_range(0, 65535);
    y   = $urandom_range(0, 65535);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5: begin
        x = $urandom_range(0, 8192) - 4096;
        y = $urandom_range(0, 8192) - 4096;
      end
      6: begin
        x = edge_value();
        y = edge_value();
        if ($urandom_range(0, 1)) yaw = edge_value();
      end
      7: begin
        x = $urandom_range(0, 4) - 2;
        y = $urandom_range(0, 4) - 2;
      end
      8: yaw = 16384 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1;
      default: begin
        yaw = 0;
        x   = -$urandom_range(1, 32768);
        y   = $urandom_range(0, 1) ? 0 : $urandom_range(0, 2) - 1;
      end
    endcase
    queue_vector($urandom_range(0, 1), yaw, x, y);
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** planar_frame_rotation: FAILED **");
    $finish;
  end

  // send side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) rotations_due.push_back(rotate_frame(in_data));
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (vectors_to_send.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= vectors_to_send.pop_front();
        if ($urandom_range(0, 49) == 0) send_burst = ~send_burst;
        send_gap = pick_gap(send_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receive side
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rotations_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected word: x=%0d y=%0d hd=%0d",
                     out_data.rot_x, out_data.rot_y, out_data.heading);
        end else begin
          want = rotations_due.pop_front();
          results_seen++;
          if (out_data.rot_x !== want.rot_x || out_data.rot_y !== want.rot_y ||
              out_data.heading !== want.heading) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected x=%0d y=%0d hd=%0d, got x=%0d y=%0d hd=%0d",
                       want.rot_x, want.rot_y, want.heading,
                       out_data.rot_x, out_data.rot_y, out_data.heading);
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 49) == 0) recv_burst = ~recv_burst;
        stall_left = pick_gap(recv_burst);
      end
    end
  end

  initial begin
    queue_vector(0, 0, 4096, 0);
    queue_vector(1, 0, 4096, 0);
    queue_vector(0, 0, 0, 0);
    queue_vector(1, 12345, 0, 0);
    queue_vector(1, -32768, 4096, 2048);
    queue_vector(0, -32768, 4096, 2048);
    queue_vector(1, 0, -4096, 0);
    queue_vector(1, 0, -4096, -1);
    queue_vector(1, 0, 0, -4096);
    queue_vector(0, 8192, 32767, 32767);
    queue_vector(1, -8192, -32768, -32768);
    queue_vector(0, 16384, 32767, -32768);
    queue_vector(1, 16384, -32768, 32767);
    queue_vector(0, -16384, 1000, -1000);
    queue_vector(0, 32767, -32768, 0);
    queue_vector(1, 32767, 32767, 0);
    queue_vector(0, 16383, 5000, 3000);
    queue_vector(1, -16385, 5000, 3000);
    queue_vector(0, 0, -32768, -32768);
    queue_vector(1, 1, 1, 1);
    queue_vector(0, -1, -1, 32767);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // hold new words until the pipe is empty
    while (results_seen != vectors_queued) @(posedge clk);
    repeat (RANDOM_WORDS / 2) queue_random_vector();
    while (results_seen != vectors_queued) @(posedge clk);
    repeat (RANDOM_WORDS - RANDOM_WORDS / 2) queue_random_vector();
    while (results_seen != vectors_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** planar_frame_rotation: PASSED **");
    end else begin
      $display("** planar_frame_rotation: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_rotator.sv
hw/rtl/pfr_gain.sv
hw/rtl/pfr_vectorer.sv
hw/rtl/planar_frame_rotation.sv
hw/rtl/pfr_checker.sv
tb/planar_frame_rotation_tb.sv
